@@ rtl/mnts_pkg.sv @@
// Package: shared constants, command codes, status types and tables of the tone sequencer.
`timescale 1ns / 1ps
package mnts_pkg;

  localparam int MAX_DOTS_DEF = 7;

  localparam int FREQ_W  = 13;
  localparam int TICKS_W = 24;
  localparam int RATE_W  = 10;
  localparam int WHOLE_W = 13;

  localparam logic [RATE_W-1:0]  TICK_RATE_RESET = 10'd100;
  localparam logic [WHOLE_W-1:0] WHOLE_RESET     = 13'd200;
  localparam logic [7:0]         TEMPO_DEFAULT   = 8'd120;
  localparam logic [7:0]         PITCH_HOME      = 8'd48;

  localparam logic [3:0] PC_NONE      = 4'd0;
  localparam logic [3:0] PC_NOTE_ACC  = 4'd1;
  localparam logic [3:0] PC_NOTE_NUM  = 4'd2;
  localparam logic [3:0] PC_NOTE_DOTS = 4'd3;
  localparam logic [3:0] PC_N_NUM     = 4'd4;
  localparam logic [3:0] PC_N_DOTS    = 4'd5;
  localparam logic [3:0] PC_P_NUM     = 4'd6;
  localparam logic [3:0] PC_P_DOTS    = 4'd7;
  localparam logic [3:0] PC_O_START   = 4'd8;
  localparam logic [3:0] PC_O_NUM     = 4'd9;
  localparam logic [3:0] PC_L_NUM     = 4'd10;
  localparam logic [3:0] PC_T_NUM     = 4'd11;
  localparam logic [3:0] PC_M_START   = 4'd12;

  localparam logic [3:0] CMD_NOP    = 4'd0;
  localparam logic [3:0] CMD_LOAD   = 4'd1;
  localparam logic [3:0] CMD_STEP   = 4'd2;
  localparam logic [3:0] CMD_DISP   = 4'd3;
  localparam logic [3:0] CMD_FLUSH  = 4'd4;
  localparam logic [3:0] CMD_JOB    = 4'd5;
  localparam logic [3:0] CMD_MUL    = 4'd6;
  localparam logic [3:0] CMD_DIVLD  = 4'd7;
  localparam logic [3:0] CMD_DIV    = 4'd8;
  localparam logic [3:0] CMD_FIN    = 4'd9;
  localparam logic [3:0] CMD_PUTSND = 4'd10;
  localparam logic [3:0] CMD_PUTSIL = 4'd11;
  localparam logic [3:0] CMD_END    = 4'd12;

  localparam logic [1:0] JOB_NONE  = 2'd0;
  localparam logic [1:0] JOB_PLAY  = 2'd1;
  localparam logic [1:0] JOB_TEMPO = 2'd2;

  typedef struct packed {
    logic [3:0] op;
  } ctrl_t;

  typedef struct packed {
    logic       absorbs;
    logic [1:0] job_kind;
    logic       cnt_zero;
    logic       put_ok;
    logic       eow;
  } status_t;

  function automatic logic [3:0] semitone(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0: s = 4'd9;
      3'd1: s = 4'd11;
      3'd2: s = 4'd0;
      3'd3: s = 4'd2;
      3'd4: s = 4'd4;
      3'd5: s = 4'd5;
      3'd6: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [FREQ_W-1:0] pitch_freq(input logic [6:0] i);
    logic [FREQ_W-1:0] f;
    case (i)
      7'd0: f = 13'd65;     7'd1: f = 13'd69;     7'd2: f = 13'd73;     7'd3: f = 13'd78;
      7'd4: f = 13'd82;     7'd5: f = 13'd87;     7'd6: f = 13'd93;     7'd7: f = 13'd98;
      7'd8: f = 13'd103;    7'd9: f = 13'd110;    7'd10: f = 13'd117;   7'd11: f = 13'd123;
      7'd12: f = 13'd131;   7'd13: f = 13'd139;   7'd14: f = 13'd147;   7'd15: f = 13'd156;
      7'd16: f = 13'd165;   7'd17: f = 13'd175;   7'd18: f = 13'd185;   7'd19: f = 13'd196;
      7'd20: f = 13'd208;   7'd21: f = 13'd220;   7'd22: f = 13'd233;   7'd23: f = 13'd247;
      7'd24: f = 13'd262;   7'd25: f = 13'd277;   7'd26: f = 13'd294;   7'd27: f = 13'd311;
      7'd28: f = 13'd330;   7'd29: f = 13'd349;   7'd30: f = 13'd370;   7'd31: f = 13'd392;
      7'd32: f = 13'd415;   7'd33: f = 13'd440;   7'd34: f = 13'd466;   7'd35: f = 13'd494;
      7'd36: f = 13'd523;   7'd37: f = 13'd554;   7'd38: f = 13'd587;   7'd39: f = 13'd622;
      7'd40: f = 13'd659;   7'd41: f = 13'd698;   7'd42: f = 13'd740;   7'd43: f = 13'd784;
      7'd44: f = 13'd831;   7'd45: f = 13'd880;   7'd46: f = 13'd932;   7'd47: f = 13'd988;
      7'd48: f = 13'd1047;  7'd49: f = 13'd1109;  7'd50: f = 13'd1175;  7'd51: f = 13'd1245;
      7'd52: f = 13'd1319;  7'd53: f = 13'd1397;  7'd54: f = 13'd1480;  7'd55: f = 13'd1568;
      7'd56: f = 13'd1661;  7'd57: f = 13'd1760;  7'd58: f = 13'd1865;  7'd59: f = 13'd1975;
      7'd60: f = 13'd2093;  7'd61: f = 13'd2217;  7'd62: f = 13'd2349;  7'd63: f = 13'd2489;
      7'd64: f = 13'd2637;  7'd65: f = 13'd2794;  7'd66: f = 13'd2960;  7'd67: f = 13'd3136;
      7'd68: f = 13'd3322;  7'd69: f = 13'd3520;  7'd70: f = 13'd3729;  7'd71: f = 13'd3951;
      7'd72: f = 13'd4186;  7'd73: f = 13'd4435;  7'd74: f = 13'd4698;  7'd75: f = 13'd4978;
      7'd76: f = 13'd5274;  7'd77: f = 13'd5588;  7'd78: f = 13'd5920;  7'd79: f = 13'd6272;
      7'd80: f = 13'd6644;  7'd81: f = 13'd7040;  7'd82: f = 13'd7459;  7'd83: f = 13'd7902;
      default: f = 13'd0;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/mnts_in_if.sv @@
// Interface: character input channel.
`timescale 1ns / 1ps
interface mnts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_write;
  modport source (output valid, character, end_of_write, input ready);
  modport sink (input valid, character, end_of_write, output ready);
endinterface

@@ rtl/mnts_out_if.sv @@
// Interface: tone and rest command output channel.
`timescale 1ns / 1ps
interface mnts_out_if;
  logic        valid;
  logic        ready;
  logic        is_rest;
  logic [12:0] frequency_hz;
  logic [23:0] ticks;
  logic        last_of_run;
  modport source (output valid, is_rest, frequency_hz, ticks, last_of_run, input ready);
  modport sink (input valid, is_rest, frequency_hz, ticks, last_of_run, output ready);
endinterface

@@ rtl/mnts_ctrl.sv @@
// Controller: sequences absorb, flush, dispatch, duration arithmetic and emission per byte.
`timescale 1ns / 1ps
module mnts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  mnts_pkg::status_t stat,
  output logic              idle,
  output mnts_pkg::ctrl_t   ctrl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_STEP  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_JOB   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIVLD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_SND   = 4'd8;
  localparam logic [3:0] S_SIL   = 4'd9;
  localparam logic [3:0] S_AFTER = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;

  logic [3:0] state, state_next;
  logic       phase, phase_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    ctrl.op    = mnts_pkg::CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = mnts_pkg::CMD_LOAD;
          phase_next = 1'b0;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        ctrl.op    = mnts_pkg::CMD_STEP;
        state_next = stat.absorbs ? S_AFTER : S_DISP;
      end
      S_DISP: begin
        ctrl.op    = mnts_pkg::CMD_DISP;
        state_next = S_JOB;
      end
      S_JOB: begin
        ctrl.op    = mnts_pkg::CMD_JOB;
        state_next = (stat.job_kind == mnts_pkg::JOB_NONE) ? S_AFTER : S_MUL;
      end
      S_MUL: begin
        if (stat.cnt_zero) state_next = S_DIVLD;
        else ctrl.op = mnts_pkg::CMD_MUL;
      end
      S_DIVLD: begin
        ctrl.op    = mnts_pkg::CMD_DIVLD;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.cnt_zero) state_next = S_FIN;
        else ctrl.op = mnts_pkg::CMD_DIV;
      end
      S_FIN: begin
        ctrl.op    = mnts_pkg::CMD_FIN;
        state_next = (stat.job_kind == mnts_pkg::JOB_PLAY) ? S_SND : S_AFTER;
      end
      S_SND: begin
        if (stat.put_ok) begin
          ctrl.op    = mnts_pkg::CMD_PUTSND;
          state_next = S_SIL;
        end
      end
      S_SIL: begin
        if (stat.put_ok) begin
          ctrl.op    = mnts_pkg::CMD_PUTSIL;
          state_next = S_AFTER;
        end
      end
      S_AFTER: begin
        if (!phase && stat.eow) begin
          ctrl.op    = mnts_pkg::CMD_FLUSH;
          phase_next = 1'b1;
          state_next = S_JOB;
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        if (stat.put_ok) begin
          ctrl.op    = mnts_pkg::CMD_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

@@ rtl/mnts_dp.sv @@
// Datapath: interpreter state, shared multiply-by-three and restoring divider, output staging.
`timescale 1ns / 1ps
module mnts_dp #(
  parameter int MAX_DOTS = mnts_pkg::MAX_DOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mnts_pkg::RATE_W-1:0] cfg_wdata,
  input  logic [7:0]                  in_character,
  input  logic                        in_end_of_write,
  input  mnts_pkg::ctrl_t             ctrl,
  output mnts_pkg::status_t           stat,
  mnts_out_if.source                  tones
);

  localparam int DW = $clog2(MAX_DOTS + 1);
  localparam int NW = (13 + 2 * MAX_DOTS > 18) ? 13 + 2 * MAX_DOTS : 18;
  localparam int CW = $clog2(NW + 1);

  function automatic logic [9:0] mag(input logic signed [9:0] v);
    return (v < 0) ? 10'(-v) : 10'(v);
  endfunction

  logic [7:0]                   char_q;
  logic                         eow_q;
  logic [mnts_pkg::RATE_W-1:0]  tick_rate;
  logic [2:0]                   octave;
  logic [mnts_pkg::WHOLE_W-1:0] whole;
  logic [3:0]                   fill;
  logic [6:0]                   deflen;
  logic                         tracking;
  logic                         oset;
  logic signed [7:0]            prev;
  logic [3:0]                   pend;
  logic [9:0]                   acc;
  logic [DW-1:0]                dots;
  logic signed [7:0]            ppitch;
  logic [1:0]                   job_kind;
  logic signed [7:0]            job_pitch;
  logic [7:0]                   job_div;
  logic [DW-1:0]                job_dots;
  logic [NW-1:0]                num;
  logic [7:0]                   rem;
  logic [CW-1:0]                cnt;
  logic [NW-1:0]                snd;
  logic [NW-1:0]                sil;
  logic [12:0]                  freq_q;
  logic                         hold_v;
  logic                         hold_rest;
  logic [12:0]                  hold_freq;
  logic [23:0]                  hold_ticks;
  logic                         out_v;

  logic [7:0]        uc;
  logic              is_dig;
  logic [13:0]       acc_mul;
  logic [9:0]        acc_dig;
  logic [DW-1:0]     dots_inc;
  logic              is_dot;
  logic              is_acc_mark;
  logic              absorbs;
  logic [6:0]        pick;
  logic              trk;
  logic signed [9:0] pw, pv, p1, p2;
  logic [9:0]        d0;
  logic              up, dn;
  logic [2:0]        o1, o2;
  logic [7:0]        tempo;
  logic [17:0]       rate240;
  logic [8:0]        rs;
  logic [NW-1:0]     total;
  logic [3:0]        kfill;
  logic [NW+3:0]     prod;
  logic [NW-1:0]     sil_val;
  logic              in_rom;
  logic              put_ok;
  logic              push;
  logic              push_last;

  assign uc       = (char_q >= 8'h61 && char_q <= 8'h7a) ? char_q - 8'd32 : char_q;
  assign is_dig   = (char_q >= 8'h30 && char_q <= 8'h39);
  assign acc_mul  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {10'd0, char_q[3:0]};
  assign acc_dig  = (acc_mul > 14'd1023) ? 10'd1023 : acc_mul[9:0];
  assign dots_inc = (dots < DW'(MAX_DOTS)) ? dots + 1'b1 : dots;
  assign is_dot   = (char_q == 8'h2e);
  assign is_acc_mark = (char_q == 8'h23 || char_q == 8'h2b || char_q == 8'h2d);

  always_comb begin
    case (pend)
      mnts_pkg::PC_NOTE_ACC:  absorbs = is_acc_mark || is_dig || is_dot;
      mnts_pkg::PC_NOTE_NUM, mnts_pkg::PC_N_NUM, mnts_pkg::PC_P_NUM:
        absorbs = is_dig || is_dot;
      mnts_pkg::PC_NOTE_DOTS, mnts_pkg::PC_N_DOTS, mnts_pkg::PC_P_DOTS:
        absorbs = is_dot;
      mnts_pkg::PC_O_START:   absorbs = (uc == 8'h4e) || (uc == 8'h4c) || is_dig;
      mnts_pkg::PC_O_NUM, mnts_pkg::PC_L_NUM, mnts_pkg::PC_T_NUM:
        absorbs = is_dig;
      mnts_pkg::PC_M_START:   absorbs = (uc == 8'h4e) || (uc == 8'h4c) || (uc == 8'h53);
      default:                absorbs = 1'b0;
    endcase
  end

  assign pick = (acc == 10'd0 || acc > 10'd64) ? deflen : acc[6:0];

  assign trk = tracking && !oset;
  assign pw  = 10'(ppitch);
  assign pv  = 10'(prev);
  assign d0  = mag(pw - pv);
  assign up  = trk && (d0 > mag(pw + 10'sd12 - pv)) && (octave < 3'd6);
  assign p1  = up ? pw + 10'sd12 : pw;
  assign o1  = up ? octave + 3'd1 : octave;
  assign dn  = trk && (d0 > mag(p1 - 10'sd12 - pv)) && (o1 != 3'd0);
  assign p2  = dn ? p1 - 10'sd12 : p1;
  assign o2  = dn ? o1 - 3'd1 : o1;

  assign tempo   = (acc < 10'd32 || acc > 10'd255) ? mnts_pkg::TEMPO_DEFAULT : acc[7:0];
  assign rate240 = {tick_rate, 8'd0} - {4'd0, tick_rate, 4'd0};
  assign rs      = {rem, num[NW-1]};
  assign total   = num >> job_dots;
  assign kfill   = 4'd8 - fill;
  assign prod    = (NW + 4)'(total) * (NW + 4)'(kfill);
  assign sil_val = NW'(prod >> 3);
  assign in_rom  = (job_pitch >= 8'sd0) && (job_pitch < 8'sd84);

  assign put_ok = !hold_v || !out_v || tones.ready;
  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    case (ctrl.op)
      mnts_pkg::CMD_PUTSND: push = hold_v && (snd != '0);
      mnts_pkg::CMD_PUTSIL: push = hold_v && (sil != '0);
      mnts_pkg::CMD_END: begin
        push      = hold_v;
        push_last = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  assign stat.absorbs  = (pend != mnts_pkg::PC_NONE) && absorbs;
  assign stat.job_kind = job_kind;
  assign stat.cnt_zero = (cnt == '0);
  assign stat.put_ok   = put_ok;
  assign stat.eow      = eow_q;

  assign tones.valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= mnts_pkg::TICK_RATE_RESET;
      octave    <= 3'd4;
      whole     <= mnts_pkg::WHOLE_RESET;
      fill      <= 4'd7;
      deflen    <= 7'd4;
      tracking  <= 1'b0;
      oset      <= 1'b1;
      prev      <= mnts_pkg::PITCH_HOME;
      pend      <= mnts_pkg::PC_NONE;
      acc       <= '0;
      dots      <= '0;
      ppitch    <= '0;
      job_kind  <= mnts_pkg::JOB_NONE;
      cnt       <= '0;
      hold_v    <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      if (cfg_we) tick_rate <= cfg_wdata;
      if (push) begin
        out_v              <= 1'b1;
        tones.is_rest      <= hold_rest;
        tones.frequency_hz <= hold_freq;
        tones.ticks        <= hold_ticks;
        tones.last_of_run  <= push_last;
      end else if (tones.ready) begin
        out_v <= 1'b0;
      end
      case (ctrl.op)
        mnts_pkg::CMD_LOAD: begin
          char_q <= in_character;
          eow_q  <= in_end_of_write;
        end
        mnts_pkg::CMD_STEP, mnts_pkg::CMD_FLUSH: begin
          if (ctrl.op == mnts_pkg::CMD_STEP && pend != mnts_pkg::PC_NONE && absorbs) begin
            case (pend)
              mnts_pkg::PC_NOTE_ACC, mnts_pkg::PC_NOTE_NUM, mnts_pkg::PC_N_NUM,
              mnts_pkg::PC_P_NUM: begin
                if (pend == mnts_pkg::PC_NOTE_ACC && is_acc_mark) begin
                  ppitch <= (char_q == 8'h2d) ? ppitch - 8'sd1 : ppitch + 8'sd1;
                  pend   <= mnts_pkg::PC_NOTE_NUM;
                end else if (is_dig) begin
                  acc <= acc_dig;
                  if (pend == mnts_pkg::PC_NOTE_ACC) pend <= mnts_pkg::PC_NOTE_NUM;
                end else begin
                  dots <= dots_inc;
                  pend <= (pend == mnts_pkg::PC_N_NUM) ? mnts_pkg::PC_N_DOTS :
                          (pend == mnts_pkg::PC_P_NUM) ? mnts_pkg::PC_P_DOTS :
                          mnts_pkg::PC_NOTE_DOTS;
                end
              end
              mnts_pkg::PC_O_START: begin
                if (uc == 8'h4e) begin
                  oset     <= 1'b0;
                  tracking <= 1'b0;
                  pend     <= mnts_pkg::PC_NONE;
                end else if (uc == 8'h4c) begin
                  tracking <= 1'b1;
                  pend     <= mnts_pkg::PC_NONE;
                end else begin
                  acc  <= acc_dig;
                  pend <= mnts_pkg::PC_O_NUM;
                end
              end
              mnts_pkg::PC_M_START: begin
                fill <= (uc == 8'h4e) ? 4'd7 : (uc == 8'h4c) ? 4'd8 : 4'd6;
                pend <= mnts_pkg::PC_NONE;
              end
              mnts_pkg::PC_NOTE_DOTS, mnts_pkg::PC_N_DOTS, mnts_pkg::PC_P_DOTS:
                dots <= dots_inc;
              default: acc <= acc_dig;
            endcase
          end else begin
            job_kind <= mnts_pkg::JOB_NONE;
            job_dots <= dots;
            case (pend)
              mnts_pkg::PC_NOTE_ACC, mnts_pkg::PC_NOTE_NUM, mnts_pkg::PC_NOTE_DOTS: begin
                octave    <= o2;
                oset      <= 1'b0;
                prev      <= p2[7:0];
                job_kind  <= mnts_pkg::JOB_PLAY;
                job_pitch <= p2[7:0];
                job_div   <= {1'b0, pick};
              end
              mnts_pkg::PC_N_NUM, mnts_pkg::PC_N_DOTS: begin
                if (acc <= 10'd84) begin
                  job_kind  <= mnts_pkg::JOB_PLAY;
                  job_pitch <= acc[7:0] - 8'sd1;
                  job_div   <= {1'b0, deflen};
                end
              end
              mnts_pkg::PC_P_NUM, mnts_pkg::PC_P_DOTS: begin
                job_kind  <= mnts_pkg::JOB_PLAY;
                job_pitch <= -8'sd1;
                job_div   <= {1'b0, pick};
              end
              mnts_pkg::PC_O_START, mnts_pkg::PC_O_NUM: begin
                octave <= (acc >= 10'd7) ? 3'd4 : acc[2:0];
                oset   <= 1'b1;
              end
              mnts_pkg::PC_L_NUM: deflen <= (acc == 10'd0 || acc > 10'd64) ? 7'd4 : acc[6:0];
              mnts_pkg::PC_T_NUM: begin
                job_kind <= mnts_pkg::JOB_TEMPO;
                job_div  <= tempo;
              end
              default: job_kind <= mnts_pkg::JOB_NONE;
            endcase
            pend <= mnts_pkg::PC_NONE;
            acc  <= '0;
            dots <= '0;
          end
        end
        mnts_pkg::CMD_DISP: begin
          if (uc >= 8'h41 && uc <= 8'h47) begin
            ppitch <= 8'({4'd0, mnts_pkg::semitone(uc[2:0] - 3'd1)}) +
                      8'({octave, 3'b000}) + 8'({octave, 2'b00});
            pend   <= mnts_pkg::PC_NOTE_ACC;
          end else begin
            case (uc)
              8'h4f: pend <= mnts_pkg::PC_O_START;
              8'h4e: pend <= mnts_pkg::PC_N_NUM;
              8'h50, 8'h7e: pend <= mnts_pkg::PC_P_NUM;
              8'h4c: pend <= mnts_pkg::PC_L_NUM;
              8'h54: pend <= mnts_pkg::PC_T_NUM;
              8'h4d: pend <= mnts_pkg::PC_M_START;
              8'h3e: begin
                if (octave < 3'd6) octave <= octave + 3'd1;
                oset <= 1'b1;
              end
              8'h3c: begin
                if (octave > 3'd0) octave <= octave - 3'd1;
                oset <= 1'b1;
              end
              default: pend <= pend;
            endcase
          end
        end
        mnts_pkg::CMD_JOB: begin
          if (job_kind == mnts_pkg::JOB_PLAY) begin
            num <= NW'(whole);
            cnt <= CW'(job_dots);
          end else begin
            num <= NW'(rate240);
            cnt <= '0;
          end
        end
        mnts_pkg::CMD_MUL: begin
          num <= num + {num[NW-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
        mnts_pkg::CMD_DIVLD: begin
          rem <= '0;
          cnt <= CW'(NW);
        end
        mnts_pkg::CMD_DIV: begin
          if (rs >= {1'b0, job_div}) begin
            rem <= 8'(rs - {1'b0, job_div});
            num <= {num[NW-2:0], 1'b1};
          end else begin
            rem <= rs[7:0];
            num <= {num[NW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        mnts_pkg::CMD_FIN: begin
          if (job_kind == mnts_pkg::JOB_TEMPO) begin
            whole <= num[mnts_pkg::WHOLE_W-1:0];
            if (job_dots == '0) job_kind <= mnts_pkg::JOB_TEMPO;
          end else begin
            if (in_rom) begin
              sil <= sil_val;
              snd <= total - sil_val;
            end else begin
              sil <= total;
              snd <= '0;
            end
            freq_q <= mnts_pkg::pitch_freq(job_pitch[6:0]);
          end
        end
        mnts_pkg::CMD_PUTSND: begin
          if (snd != '0) begin
            hold_v     <= 1'b1;
            hold_rest  <= 1'b0;
            hold_freq  <= freq_q;
            hold_ticks <= 24'(snd);
          end
        end
        mnts_pkg::CMD_PUTSIL: begin
          if (sil != '0) begin
            hold_v     <= 1'b1;
            hold_rest  <= 1'b1;
            hold_freq  <= '0;
            hold_ticks <= 24'(sil);
          end
        end
        mnts_pkg::CMD_END: begin
          hold_v <= 1'b0;
          if (eow_q) prev <= mnts_pkg::PITCH_HOME;
        end
        default: hold_v <= hold_v;
      endcase
    end
  end

endmodule

@@ rtl/music_notation_tone_sequencer.sv @@
// Top level: music notation tone sequencer, controller plus datapath.
`timescale 1ns / 1ps
// Interprets a PLAY-style music string byte by byte and emits tone and rest beats.
// One byte at a time is taken. A byte that only extends the pending command skips
// dispatch; a byte that completes a note runs the dot multiply steps, then the shared
// restoring divider at one quotient bit per cycle (13 + 2*MAX_DOTS bits, at least 18;
// 27 by default), again if end_of_write flushes a second note. A tempo command uses the
// same divider. Output beats sit in a register, so one result may wait downstream while
// the next is computed; the final beat of a byte carries last_of_run.
module music_notation_tone_sequencer #(
  parameter int MAX_DOTS = mnts_pkg::MAX_DOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mnts_pkg::RATE_W-1:0] cfg_wdata,
  mnts_in_if.sink                     chars,
  mnts_out_if.source                  tones
);

  mnts_pkg::ctrl_t   ctrl;
  mnts_pkg::status_t stat;
  logic              idle;

  assign chars.ready = idle;

  mnts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .stat     (stat),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  mnts_dp #(.MAX_DOTS(MAX_DOTS)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_character    (chars.character),
    .in_end_of_write (chars.end_of_write),
    .ctrl            (ctrl),
    .stat            (stat),
    .tones           (tones)
  );

endmodule

@@ rtl/mnts_check.sv @@
// Checker: port-level properties of the tone sequencer, bound to the top level.
`timescale 1ns / 1ps
module mnts_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_rest,
  input logic [12:0] frequency_hz,
  input logic [23:0] ticks
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready after accepting a beat");

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ticks != 24'd0)
    else $error("zero-length beat");

  a_rest_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_rest |-> frequency_hz == 13'd0)
    else $error("rest with a frequency");

  a_tone_audible: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_rest |-> frequency_hz != 13'd0)
    else $error("tone without a frequency");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ticks))
    else $error("stalled output beat changed");

endmodule

bind music_notation_tone_sequencer mnts_check u_mnts_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (chars.valid),
  .in_ready     (chars.ready),
  .out_valid    (tones.valid),
  .out_ready    (tones.ready),
  .is_rest      (tones.is_rest),
  .frequency_hz (tones.frequency_hz),
  .ticks        (tones.ticks)
);

@@ tb/testbench.sv @@
// Testbench: drives the tone sequencer with notation bytes and checks every tone/rest beat.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    bit        rest;
    bit [12:0] freq;
    bit [23:0] ticks;
    bit        last;
  } tone_t;

  typedef struct {
    bit [7:0] c;
    bit       eow;
  } char_t;

  localparam int LIMIT = 1000000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [mnts_pkg::RATE_W-1:0] cfg_wdata = '0;

  mnts_in_if chars ();
  mnts_out_if tones ();

  music_notation_tone_sequencer i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .chars(chars), .tones(tones)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  const int unsigned freq_rom [84] = '{
    65, 69, 73, 78, 82, 87, 93, 98, 103, 110, 117, 123,
    131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
    262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
    1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1975,
    2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951,
    4186, 4435, 4698, 4978, 5274, 5588, 5920, 6272, 6644, 7040, 7459, 7902};
  const int unsigned note_semi [7] = '{9, 11, 0, 2, 4, 5, 7};

  int unsigned seq_rate = 100, seq_oct = 4, seq_whole = 200, seq_fill = 7, seq_deflen = 4;
  int unsigned seq_acc = 0, seq_dots = 0;
  bit seq_track = 0, seq_oset = 1;
  int seq_prev = 48, seq_pitch = 0;
  logic [3:0] seq_pend = mnts_pkg::PC_NONE;

  tone_t byte_tones[$];
  tone_t tone_q[$];
  char_t feed_q[$];
  int errors = 0;
  int items = 0;
  bit quiet = 0;
  int hold_req = 0;

  function automatic void put_tone(bit rest, int unsigned f, longint unsigned t);
    tone_t r;
    if (byte_tones.size() >= 4) return;
    r.rest = rest; r.freq = f[12:0]; r.ticks = t[23:0]; r.last = 0;
    byte_tones.push_back(r);
  endfunction

  function automatic void sound_note(int p, int unsigned len, int unsigned dots);
    longint unsigned w, d, total, sil;
    w = seq_whole;
    d = (len != 0) ? len : 1;
    for (int i = 0; i < dots; i++) begin
      w = w * 3; d = d * 2;
    end
    total = w / d;
    if (p < 0 || p > 83) begin
      if (total != 0) put_tone(1, 0, total);
      return;
    end
    sil = total * (8 - seq_fill) / 8;
    if (total - sil != 0) put_tone(0, freq_rom[p], total - sil);
    if (sil != 0) put_tone(1, 0, sil);
  endfunction

  function automatic int unsigned note_len(int unsigned v);
    return (v == 0 || v > 64) ? seq_deflen : v;
  endfunction

  function automatic int iabs(int a);
    return a < 0 ? -a : a;
  endfunction

  function automatic void complete_cmd();
    int p, d;
    case (seq_pend)
      mnts_pkg::PC_NOTE_ACC, mnts_pkg::PC_NOTE_NUM, mnts_pkg::PC_NOTE_DOTS: begin
        p = seq_pitch;
        if (seq_track && !seq_oset) begin
          d = iabs(p - seq_prev);
          if (d > iabs(p + 12 - seq_prev) && seq_oct < 6) begin
            seq_oct++; p += 12;
          end
          if (d > iabs(p - 12 - seq_prev) && seq_oct > 0) begin
            seq_oct--; p -= 12;
          end
        end
        seq_oset = 0;
        seq_prev = p;
        sound_note(p, note_len(seq_acc), seq_dots);
      end
      mnts_pkg::PC_N_NUM, mnts_pkg::PC_N_DOTS:
        if (seq_acc <= 84) sound_note(int'(seq_acc) - 1, seq_deflen, seq_dots);
      mnts_pkg::PC_P_NUM, mnts_pkg::PC_P_DOTS: sound_note(-1, note_len(seq_acc), seq_dots);
      mnts_pkg::PC_O_START, mnts_pkg::PC_O_NUM: begin
        seq_oct = (seq_acc >= 7) ? 4 : seq_acc;
        seq_oset = 1;
      end
      mnts_pkg::PC_L_NUM: seq_deflen = (seq_acc == 0 || seq_acc > 64) ? 4 : seq_acc;
      mnts_pkg::PC_T_NUM:
        seq_whole = seq_rate * 240 / ((seq_acc < 32 || seq_acc > 255) ? 120 : seq_acc);
      default: ;
    endcase
    seq_pend = mnts_pkg::PC_NONE;
    seq_acc = 0;
    seq_dots = 0;
  endfunction

  function automatic void take_digit(int unsigned c);
    seq_acc = seq_acc * 10 + (c - "0");
    if (seq_acc > 1023) seq_acc = 1023;
  endfunction

  function automatic bit extend_cmd(int unsigned c);
    bit dig;
    logic [3:0] pc;
    dig = c >= "0" && c <= "9";
    pc = seq_pend;
    case (pc)
      mnts_pkg::PC_NOTE_ACC, mnts_pkg::PC_NOTE_NUM, mnts_pkg::PC_N_NUM,
      mnts_pkg::PC_P_NUM: begin
        if (pc == mnts_pkg::PC_NOTE_ACC && (c == "#" || c == "+" || c == "-")) begin
          seq_pitch += (c == "-") ? -1 : 1;
          seq_pend = mnts_pkg::PC_NOTE_NUM;
          return 1;
        end
        if (dig) begin
          take_digit(c);
          if (pc == mnts_pkg::PC_NOTE_ACC) seq_pend = mnts_pkg::PC_NOTE_NUM;
          return 1;
        end
        if (c == ".") begin
          if (seq_dots < mnts_pkg::MAX_DOTS_DEF) seq_dots++;
          seq_pend = (pc == mnts_pkg::PC_N_NUM) ? mnts_pkg::PC_N_DOTS :
                     (pc == mnts_pkg::PC_P_NUM) ? mnts_pkg::PC_P_DOTS :
                     mnts_pkg::PC_NOTE_DOTS;
          return 1;
        end
        return 0;
      end
      mnts_pkg::PC_NOTE_DOTS, mnts_pkg::PC_N_DOTS, mnts_pkg::PC_P_DOTS: begin
        if (c == ".") begin
          if (seq_dots < mnts_pkg::MAX_DOTS_DEF) seq_dots++;
          return 1;
        end
        return 0;
      end
      mnts_pkg::PC_O_START: begin
        if (c == "N" || c == "n") begin
          seq_oset = 0; seq_track = 0; seq_pend = mnts_pkg::PC_NONE;
          return 1;
        end
        if (c == "L" || c == "l") begin
          seq_track = 1; seq_pend = mnts_pkg::PC_NONE;
          return 1;
        end
        if (dig) begin
          take_digit(c); seq_pend = mnts_pkg::PC_O_NUM;
          return 1;
        end
        return 0;
      end
      mnts_pkg::PC_O_NUM, mnts_pkg::PC_L_NUM, mnts_pkg::PC_T_NUM: begin
        if (dig) take_digit(c);
        return dig;
      end
      mnts_pkg::PC_M_START: begin
        if (c == "N" || c == "n") seq_fill = 7;
        else if (c == "L" || c == "l") seq_fill = 8;
        else if (c == "S" || c == "s") seq_fill = 6;
        else return 0;
        seq_pend = mnts_pkg::PC_NONE;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void start_cmd(int unsigned c);
    if (c >= "a" && c <= "z") c -= 32;
    if (c >= "A" && c <= "G") begin
      seq_pitch = note_semi[c - "A"] + seq_oct * 12;
      seq_pend = mnts_pkg::PC_NOTE_ACC;
      return;
    end
    case (c)
      "O": seq_pend = mnts_pkg::PC_O_START;
      "N": seq_pend = mnts_pkg::PC_N_NUM;
      "P", "~": seq_pend = mnts_pkg::PC_P_NUM;
      "L": seq_pend = mnts_pkg::PC_L_NUM;
      "T": seq_pend = mnts_pkg::PC_T_NUM;
      "M": seq_pend = mnts_pkg::PC_M_START;
      ">": begin
        if (seq_oct < 6) seq_oct++;
        seq_oset = 1;
      end
      "<": begin
        if (seq_oct > 0) seq_oct--;
        seq_oset = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic void send_char(bit [7:0] c, bit eow);
    char_t it;
    byte_tones.delete();
    if (seq_pend == mnts_pkg::PC_NONE || !extend_cmd(c)) begin
      complete_cmd();
      start_cmd(c);
    end
    if (eow) begin
      complete_cmd();
      seq_prev = 48;
    end
    if (byte_tones.size() > 0) byte_tones[byte_tones.size() - 1].last = 1;
    foreach (byte_tones[i]) tone_q.push_back(byte_tones[i]);
    it.c = c; it.eow = eow;
    feed_q.push_back(it);
    items++;
  endfunction

  function automatic void send_str(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endfunction

  function automatic bit [7:0] maybe_lower(bit [7:0] c);
    return $urandom_range(0, 1) ? c + 8'd32 : c;
  endfunction

  function automatic void send_rand(bit [7:0] c);
    send_char(c, $urandom_range(0, 11) == 0);
  endfunction

  function automatic void send_num(int unsigned v);
    string s;
    s.itoa(v);
    for (int i = 0; i < s.len(); i++) send_rand(s[i]);
  endfunction

  function automatic void send_phrase();
    int k;
    k = $urandom_range(0, 15);
    case (k)
      0, 1, 2, 3, 4, 5: begin
        send_rand(maybe_lower(8'("A" + $urandom_range(0, 6))));
        case ($urandom_range(0, 3))
          0: send_rand("#");
          1: send_rand("+");
          2: send_rand("-");
          default: ;
        endcase
        if ($urandom_range(0, 1)) send_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 1100)
                                                                      : $urandom_range(1, 16));
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(0, 9) : 0) send_rand(".");
      end
      6: begin
        send_rand(maybe_lower("N"));
        send_num($urandom_range(0, 90));
        repeat ($urandom_range(0, 2)) send_rand(".");
      end
      7: begin
        send_rand($urandom_range(0, 1) ? 8'("~") : maybe_lower("P"));
        if ($urandom_range(0, 3) != 0) send_num($urandom_range(0, 70));
        repeat ($urandom_range(0, 2)) send_rand(".");
      end
      8: begin
        send_rand(maybe_lower("O"));
        case ($urandom_range(0, 3))
          0: send_rand(maybe_lower("L"));
          1: send_rand(maybe_lower("N"));
          default: send_num($urandom_range(0, 8));
        endcase
      end
      9: send_rand($urandom_range(0, 1) ? 8'("<") : 8'(">"));
      10: begin
        send_rand(maybe_lower("L"));
        send_num($urandom_range(0, 70));
      end
      11: begin
        send_rand(maybe_lower("T"));
        send_num($urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom_range(32, 255));
      end
      12: begin
        send_rand(maybe_lower("M"));
        case ($urandom_range(0, 3))
          0: send_rand(maybe_lower("N"));
          1: send_rand(maybe_lower("L"));
          2: send_rand(maybe_lower("S"));
          default: send_rand(8'($urandom_range(0, 255)));
        endcase
      end
      default: send_rand(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic drain();
    while (feed_q.size() != 0 || chars.valid || tone_q.size() != 0) @(negedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_rate(int unsigned v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v[mnts_pkg::RATE_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    seq_rate = v & 32'h3FF;
  endtask

  task automatic run_phrases(int n);
    int stop;
    stop = items + n;
    while (items < stop) send_phrase();
  endtask

  int gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      chars.valid <= 0;
      chars.character <= '0;
      chars.end_of_write <= 0;
    end else if (!chars.valid || chars.ready) begin
      if (gap > 0) begin
        gap <= gap - 1;
        chars.valid <= 0;
      end else if (feed_q.size() != 0) begin
        chars.valid <= 1;
        chars.character <= feed_q[0].c;
        chars.end_of_write <= feed_q[0].eow;
        void'(feed_q.pop_front());
        if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 3);
      end else begin
        chars.valid <= 0;
      end
    end
  end

  int hold = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold <= 600;
    end else if (hold > 0) begin
      hold <= hold - 1;
    end
  end

  int stall = 0;
  always @(posedge clk) begin
    tone_t want;
    if (rst) begin
      tones.ready <= 0;
    end else begin
      if (tones.valid && tones.ready) begin
        if (tone_q.size() == 0) begin
          $display("%0t: unexpected beat rest=%0d freq=%0d ticks=%0d last=%0d", $time,
                   tones.is_rest, tones.frequency_hz, tones.ticks, tones.last_of_run);
          errors++;
        end else begin
          want = tone_q.pop_front();
          if (tones.is_rest !== want.rest || tones.frequency_hz !== want.freq ||
              tones.ticks !== want.ticks || tones.last_of_run !== want.last) begin
            $display("%0t: expected rest=%0d freq=%0d ticks=%0d last=%0d", $time,
                     want.rest, want.freq, want.ticks, want.last);
            $display("%0t: actual   rest=%0d freq=%0d ticks=%0d last=%0d", $time,
                     tones.is_rest, tones.frequency_hz, tones.ticks, tones.last_of_run);
            errors++;
          end
        end
      end
      if (hold_req != hold_seen || hold > 0) begin
        tones.ready <= 0;
      end else if (stall > 0) begin
        stall <= stall - 1;
        tones.ready <= 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall <= $urandom_range(0, 2);
        tones.ready <= 0;
      end else begin
        tones.ready <= 1;
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    send_str("O0C-");
    send_str("O6B#");
    send_str("N0N84N85..");
    send_str("P99999C#.........");
    send_str("MLOL>c<");
    send_str("T255L0mSb");
    send_str("O7");
    send_str("O");
    send_str("M");
    drain();

    write_rate(1);
    send_str("T32");
    run_phrases(60);
    drain();

    write_rate(1000);
    send_str("T255");
    hold_req = 1;
    run_phrases(80);
    drain();

    write_rate(0);
    send_str("T");
    run_phrases(30);
    drain();

    write_rate(1023);
    send_str("T32");
    run_phrases(60);
    drain();

    write_rate($urandom_range(1, 1000));
    run_phrases(85);
    drain();

    write_rate(100);
    quiet = 1;
    send_str("T");
    run_phrases(80);
    drain();

    if (errors == 0 && tone_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
